### sv/bb_pkg.sv
// Shared types, constants and rounding arithmetic for the 3x3 RGB box blur.
// No dependencies; used by the top level.
`default_nettype none

package bb_pkg;

   localparam int CH_W        = 8;   // bits per color channel
   localparam int LW_W        = 11;  // line_width register field
   localparam int FH_W        = 13;  // frame_height register field
   localparam int CSR_W       = 13;  // widest register
   localparam int CSR_IDX_W   = 1;
   localparam int SUM_W       = 12;  // up to 9 * 255
   localparam int CNT_W       = 4;   // neighbour count, 1..9
   localparam int OFIFO_DEPTH = 8;
   localparam int OFIFO_AW    = 3;
   localparam int OFIFO_CW    = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // func codes
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   // reciprocals: floor(x/3) = (x*10923)>>15, floor(x/9) = (x*7282)>>16, x < 2^12
   localparam logic [13:0] DIV3_MUL = 14'd10923;
   localparam logic [12:0] DIV9_MUL = 13'd7282;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_pair_type;

   // which window rows/columns lie inside the frame, plus last-of-frame flag
   typedef struct packed {
      logic row_top;
      logic row_bot;
      logic col_left;
      logic col_right;
      logic last;
   } border_type;

   typedef struct packed {
      logic [CH_W-1:0] red_out;
      logic [CH_W-1:0] green_out;
      logic [CH_W-1:0] blue_out;
      logic            frame_end;
   } result_type;

   function automatic logic [CH_W-1:0] div3(input logic [SUM_W-1:0] x);
      logic [25:0] prod;
      prod = 26'(x) * 26'(DIV3_MUL);
      return prod[22:15];
   endfunction

   function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] x);
      logic [24:0] prod;
      prod = 25'(x) * 25'(DIV9_MUL);
      return prod[23:16];
   endfunction

   // (2*sum + cnt) / (2*cnt), i.e. mean rounded half up
   function automatic logic [CH_W-1:0] round_mean(input logic [SUM_W-1:0] sum,
                                                  input logic [CNT_W-1:0] cnt);
      logic [SUM_W:0]  num;
      logic [CH_W-1:0] q;
      num = {sum, 1'b0} + (SUM_W+1)'(cnt);
      case (cnt)
         4'd1:    q = num[CH_W:1];
         4'd2:    q = num[CH_W+1:2];
         4'd4:    q = num[CH_W+2:3];
         4'd3:    q = div3(num[SUM_W:1]);
         4'd6:    q = div3({1'b0, num[SUM_W:2]});
         4'd9:    q = div9(num[SUM_W:1]);
         default: q = '0;
      endcase
      return q;
   endfunction

endpackage

`default_nettype wire

### sv/bb_ifs.sv
// Valid/ready stream interfaces for the box blur: pixel requests and results.
// Depends on nothing but the payload field widths.
`default_nettype none

interface bb_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;

   modport source (output valid, func, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, func, red_in, green_in, blue_in, output ready);
endinterface

interface bb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic       frame_end;

   modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

`default_nettype wire

### sv/box_blur_3x3_rgb.sv
// 3x3 box blur over an RGB raster stream; depends on bb_pkg, bb_req_if and bb_rsp_if.
// Path: a result is registered in S1, S2, S3 and the queue after the transfer causing it,
//   on top of the stream lag of one row plus one pixel that flush items drain.
// Throughput: one transfer per cycle; req ready drops only when 8 results are pending
//   in the pipeline and the output queue, which sets the stall depth.
// Reset: synchronous, active high; clears control and window only (stale data masked).
`default_nettype none

module box_blur_3x3_rgb #(
   parameter int MAX_LINE_WIDTH   = 1024,
   parameter int MAX_FRAME_HEIGHT = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   bb_req_if.sink                             req_chan,
   bb_rsp_if.source                           rsp_chan,
   input  wire logic                          csr_we,
   input  wire logic [bb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bb_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int COL_W  = $clog2(MAX_LINE_WIDTH);       // column / line store address
   localparam int OROW_W = $clog2(MAX_FRAME_HEIGHT + 1);
   localparam int IROW_W = $clog2(MAX_FRAME_HEIGHT + 2); // input row runs past the frame

   // ---------------------------------------------------------------------------------
   // Configuration registers (clamped on write) and position counters
   // ---------------------------------------------------------------------------------
   logic [bb_pkg::LW_W-1:0] lw_ff, lw_in;
   logic [bb_pkg::FH_W-1:0] fh_ff, fh_in;
   logic [COL_W-1:0]        in_col_ff, in_col_in;
   logic [IROW_W-1:0]       in_row_ff, in_row_in;
   logic [COL_W-1:0]        out_col_ff, out_col_in;
   logic [OROW_W-1:0]       out_row_ff, out_row_in;

   logic [bb_pkg::LW_W-1:0] lw_wr;
   logic [bb_pkg::FH_W-1:0] fh_wr;

   // input transfer decode
   logic              accept;
   logic              draining;
   logic              act;       // item that shifts the window (not an ignored flush)
   logic              emit;      // this item completes a window
   logic              col_wrap;
   bb_pkg::pixel_type fresh;
   bb_pkg::border_type border;

   // pipeline: S1 = line store read, S2 = window valid, S3 = sums
   logic                  s1_vld_ff;
   logic                  s1_emit_ff;
   logic [COL_W-1:0]      s1_addr_ff;
   bb_pkg::pixel_type     s1_fresh_ff;
   bb_pkg::border_type    s1_border_ff;

   bb_pkg::line_pair_type line_mem [MAX_LINE_WIDTH];
   bb_pkg::line_pair_type mem_q_ff;
   bb_pkg::line_pair_type byp_data_ff;
   logic                  byp_ff;
   bb_pkg::line_pair_type line_rd;
   bb_pkg::line_pair_type wr_pair;

   bb_pkg::pixel_type     win_ff [3][3];   // [row][column], column 2 newest

   logic                  s2_vld_ff;
   bb_pkg::border_type    s2_border_ff;
   logic [bb_pkg::SUM_W-1:0] sum_r, sum_g, sum_b;
   logic [bb_pkg::CNT_W-1:0] cnt_s2;

   logic                  s3_vld_ff;
   logic                  s3_last_ff;
   logic [bb_pkg::SUM_W-1:0] s3_sum_r_ff, s3_sum_g_ff, s3_sum_b_ff;
   logic [bb_pkg::CNT_W-1:0] s3_cnt_ff;

   // output queue
   bb_pkg::result_type       ofifo_mem [bb_pkg::OFIFO_DEPTH];
   logic [bb_pkg::OFIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [bb_pkg::OFIFO_CW-1:0] ocnt_ff, ocnt_in;
   logic                     push, pop;
   logic [1:0]               pend;
   bb_pkg::result_type       push_data;

   assign accept   = req_chan.valid && req_chan.ready;
   assign draining = 32'(in_row_ff) >= 32'(fh_ff);
   assign act      = accept && ((req_chan.func == bb_pkg::FUNC_PIXEL) || draining);
   assign emit     = (32'(in_row_ff) >= 32'd2) ||
                     ((32'(in_row_ff) == 32'd1) && (in_col_ff != '0));
   assign col_wrap = (32'(in_col_ff) + 32'd1) >= 32'(lw_ff);

   always_comb begin
      if (draining) begin
         fresh = '0;      // tail drain: pixel data is discarded
      end else begin
         fresh.red   = req_chan.red_in;
         fresh.green = req_chan.green_in;
         fresh.blue  = req_chan.blue_in;
      end
   end

   // window clipping for the output position being completed
   always_comb begin
      border.row_top   = out_row_ff != '0;
      border.row_bot   = (32'(out_row_ff) + 32'd1) < 32'(fh_ff);
      border.col_left  = out_col_ff != '0;
      border.col_right = (32'(out_col_ff) + 32'd1) < 32'(lw_ff);
      border.last      = !border.row_bot && !border.col_right;
   end

   // a value of 0 acts as 1, anything above the maximum acts as the maximum
   always_comb begin
      if (csr_wdata[bb_pkg::LW_W-1:0] == '0) begin
         lw_wr = bb_pkg::LW_W'(1);
      end else if (32'(csr_wdata[bb_pkg::LW_W-1:0]) > MAX_LINE_WIDTH) begin
         lw_wr = bb_pkg::LW_W'(MAX_LINE_WIDTH);
      end else begin
         lw_wr = csr_wdata[bb_pkg::LW_W-1:0];
      end
      if (csr_wdata[bb_pkg::FH_W-1:0] == '0) begin
         fh_wr = bb_pkg::FH_W'(1);
      end else if (32'(csr_wdata[bb_pkg::FH_W-1:0]) > MAX_FRAME_HEIGHT) begin
         fh_wr = bb_pkg::FH_W'(MAX_FRAME_HEIGHT);
      end else begin
         fh_wr = csr_wdata[bb_pkg::FH_W-1:0];
      end
   end

   always_comb begin
      lw_in      = lw_ff;
      fh_in      = fh_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;

      if (act) begin
         if (col_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + IROW_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
         if (emit) begin
            if (border.last) begin
               // frame done: every position counter restarts
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end else if (!border.col_right) begin
               out_col_in = '0;
               out_row_in = out_row_ff + OROW_W'(1);
            end else begin
               out_col_in = out_col_ff + COL_W'(1);
            end
         end
      end

      // any register write restarts the frame
      if (csr_we) begin
         unique case (csr_index)
            bb_pkg::CSR_LINE_WIDTH:   lw_in = lw_wr;
            bb_pkg::CSR_FRAME_HEIGHT: fh_in = fh_wr;
            default:                  ;
         endcase
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_ff      <= bb_pkg::LW_W'(640);
         fh_ff      <= bb_pkg::FH_W'(480);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         lw_ff      <= lw_in;
         fh_ff      <= fh_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // S1: line stores. Both rows live in one memory entry per column; the entry is read
   // on the transfer and rewritten in the next cycle. Back-to-back hits on the same
   // column (line width 1) take the in-flight write data instead of the stale read.
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s1_emit_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= act;
         s1_emit_ff <= act && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (act) begin
         s1_addr_ff   <= in_col_ff;
         s1_fresh_ff  <= fresh;
         s1_border_ff <= border;
      end
   end

   assign line_rd        = byp_ff ? byp_data_ff : mem_q_ff;
   assign wr_pair.upper  = line_rd.middle;
   assign wr_pair.middle = s1_fresh_ff;

   always_ff @(posedge clock) begin
      if (act) begin
         mem_q_ff    <= line_mem[in_col_ff];
         byp_ff      <= s1_vld_ff && (s1_addr_ff == in_col_ff);
         byp_data_ff <= wr_pair;
      end
      if (s1_vld_ff) begin
         line_mem[s1_addr_ff] <= wr_pair;
      end
   end

   // window shift on every S1 item
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (s1_vld_ff) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= line_rd.upper;
         win_ff[1][2] <= line_rd.middle;
         win_ff[2][2] <= s1_fresh_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // S2: masked sums over the window and the in-frame neighbour count
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_emit_ff) begin
         s2_border_ff <= s1_border_ff;
      end
   end

   always_comb begin
      logic [2:0] row_ok;
      logic [2:0] col_ok;
      logic [1:0] rows;
      logic [1:0] cols;
      row_ok = {s2_border_ff.row_bot, 1'b1, s2_border_ff.row_top};
      col_ok = {s2_border_ff.col_right, 1'b1, s2_border_ff.col_left};
      rows   = 2'd1 + 2'(s2_border_ff.row_top) + 2'(s2_border_ff.row_bot);
      cols   = 2'd1 + 2'(s2_border_ff.col_left) + 2'(s2_border_ff.col_right);
      cnt_s2 = bb_pkg::CNT_W'(rows) * bb_pkg::CNT_W'(cols);
      sum_r  = '0;
      sum_g  = '0;
      sum_b  = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (row_ok[i] && col_ok[j]) begin
               sum_r = sum_r + bb_pkg::SUM_W'(win_ff[i][j].red);
               sum_g = sum_g + bb_pkg::SUM_W'(win_ff[i][j].green);
               sum_b = sum_b + bb_pkg::SUM_W'(win_ff[i][j].blue);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // S3: rounded division by the count, pushed into the output queue
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_vld_ff) begin
         s3_sum_r_ff <= sum_r;
         s3_sum_g_ff <= sum_g;
         s3_sum_b_ff <= sum_b;
         s3_cnt_ff   <= cnt_s2;
         s3_last_ff  <= s2_border_ff.last;
      end
   end

   assign push                = s3_vld_ff;
   assign push_data.red_out   = bb_pkg::round_mean(s3_sum_r_ff, s3_cnt_ff);
   assign push_data.green_out = bb_pkg::round_mean(s3_sum_g_ff, s3_cnt_ff);
   assign push_data.blue_out  = bb_pkg::round_mean(s3_sum_b_ff, s3_cnt_ff);
   assign push_data.frame_end = s3_last_ff;

   // ---------------------------------------------------------------------------------
   // Output queue. Ready reserves room for every result still in the pipeline, so the
   // pipeline never stalls and req ready does not depend on rsp ready.
   // ---------------------------------------------------------------------------------
   assign pop     = rsp_chan.valid && rsp_chan.ready;
   assign pend    = 2'(s1_emit_ff) + 2'(s2_vld_ff) + 2'(s3_vld_ff);
   assign ocnt_in = ocnt_ff + bb_pkg::OFIFO_CW'(push) - bb_pkg::OFIFO_CW'(pop);

   assign req_chan.ready = ((bb_pkg::OFIFO_CW + 1)'(ocnt_ff) + (bb_pkg::OFIFO_CW + 1)'(pend))
                           < (bb_pkg::OFIFO_CW + 1)'(bb_pkg::OFIFO_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         ocnt_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + bb_pkg::OFIFO_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + bb_pkg::OFIFO_AW'(1);
         end
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ofifo_mem[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_chan.valid     = ocnt_ff != '0;
   assign rsp_chan.red_out   = ofifo_mem[rd_ptr_ff].red_out;
   assign rsp_chan.green_out = ofifo_mem[rd_ptr_ff].green_out;
   assign rsp_chan.blue_out  = ofifo_mem[rd_ptr_ff].blue_out;
   assign rsp_chan.frame_end = ofifo_mem[rd_ptr_ff].frame_end;

endmodule

`default_nettype wire

### sv/bb_checker.sv
// Port-level checks for box_blur_3x3_rgb, attached by the bind at the end.
// Depends on the top level's port list only.
`default_nettype none

module bb_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] red_out,
   input wire logic [7:0] green_out,
   input wire logic [7:0] blue_out,
   input wire logic       frame_end
);

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(red_out) && $stable(green_out) &&
                                  $stable(blue_out) && $stable(frame_end))
      else $error("result changed while stalled");

   // reset leaves the block empty and ready
   a_reset_empty: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not empty after reset");

   // a fresh result follows a transfer through S1, S2, S3 and the output queue count
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 4))
      else $error("result without a transfer four cycles before");

endmodule

bind box_blur_3x3_rgb bb_checker u_bb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .red_out   (rsp_chan.red_out),
   .green_out (rsp_chan.green_out),
   .blue_out  (rsp_chan.blue_out),
   .frame_end (rsp_chan.frame_end)
);

`default_nettype wire
